### hdl/rs15_10_erasure_error_decoder_top_assert.svh
// Assertion macros for the RS(15,10) decoder.
`ifndef RS15_10_ERASURE_ERROR_DECODER_TOP_ASSERT_SVH
`define RS15_10_ERASURE_ERROR_DECODER_TOP_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define RS15_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define RS15_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rs15_pkg.sv
`default_nettype none

package rs15_pkg;

  typedef logic [3:0] gf_t;

  localparam logic [3:0] LAST_POS    = 4'd14;
  localparam logic [3:0] GF_ORDER    = 4'd15;
  localparam logic [3:0] MAX_FIX     = 4'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FIXED = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  localparam gf_t EXP_TAB [16] = '{
    4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
    4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9, 4'd0
  };
  localparam gf_t LOG_TAB [16] = '{
    4'd15, 4'd0, 4'd1, 4'd4, 4'd2, 4'd8, 4'd5, 4'd10,
    4'd3, 4'd14, 4'd9, 4'd7, 4'd6, 4'd13, 4'd11, 4'd12
  };

  typedef enum logic [4:0] {
    S_LOAD,
    S_SYN,
    S_SYN_CHK,
    S_ERA_SCAN,
    S_ERA_UPD,
    S_ERA_DONE,
    S_BM_DISC,
    S_BM_DEC,
    S_BM_T,
    S_BM_C,
    S_BM_END,
    S_DEG,
    S_CHIEN,
    S_CHK,
    S_EVAL,
    S_FN_NUM,
    S_FN_DEN,
    S_FN_VAL,
    S_OUT
  } state_t;

  function automatic logic [3:0] add15(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, GF_ORDER}) begin
      s = s - {1'b0, GF_ORDER};
    end
    return s[3:0];
  endfunction

  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    gf_t p;
    if (a == 4'd0 || b == 4'd0) begin
      p = 4'd0;
    end else begin
      p = EXP_TAB[add15(LOG_TAB[a], LOG_TAB[b])];
    end
    return p;
  endfunction

  function automatic gf_t gf_inv(input gf_t a);
    gf_t p;
    if (a == 4'd0) begin
      p = 4'd0;
    end else if (LOG_TAB[a] == 4'd0) begin
      p = 4'd1;
    end else begin
      p = EXP_TAB[GF_ORDER - LOG_TAB[a]];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hdl/rs15_10_erasure_error_decoder_top.sv
// Channel   Dir  tdata / tuser / tlast
// s_*       in   tdata[3:0] symbol; tuser erased
// m_*       out  tdata[3:0] symbol_res, [7:4] position, [9:8] status,
//                [12:10] fixed_count; tlast on position 14
// Fifteen input transactions load one codeword, at most one per cycle.
// Decoding then computes the syndromes and goes straight to output when they are zero or
// there are too many erasures, else it runs erasure seeding, Berlekamp-Massey, the Chien
// search and Forney on one shared GF(16) multiplier. Then fifteen output transactions,
// one per cycle while m_tready is high. s_tready is high only while loading; m_tvalid
// only while emitting; a stalled output holds the decoder. Reset clears the sequencer
// and the load counters.
`default_nettype none

`include "rs15_10_erasure_error_decoder_top_assert.svh"

module rs15_10_erasure_error_decoder_top
  import rs15_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [3:0] symbol, [7:4] zero
  input  wire logic        s_tuser,   // [0] erased
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] symbol_res, [7:4] position,
                                      // [9:8] status, [12:10] fixed_count
  output logic             m_tlast
);

  state_t state, state_next;

  gf_t  rw [15];
  logic em [15];
  gf_t  syn [5];
  gf_t  loc [6];
  gf_t  corr [6];
  gf_t  tp [6];
  gf_t  ev [5];
  gf_t  roots [5];
  gf_t  vals [5];

  logic [3:0] idx, outer, erasures, cnt, el, ex;
  logic [2:0] inner, r, deg;
  gf_t        acc, d, num;
  logic       nz, take;
  logic [1:0] status;

  gf_t        mul_a, mul_b, prod, sum, root_v, fix;
  logic [3:0] step, root_m;
  logic [2:0] top_eval, top_den, deg_calc;
  logic [4:0] lhs, rhs;
  logic       bm_take, in_acc, out_acc, chk_fail;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_comb begin
    root_v = (state == S_FN_NUM || state == S_FN_DEN || state == S_FN_VAL) ?
             roots[outer[2:0]] : 4'd0;
    root_m = (root_v == GF_ORDER) ? 4'd0 : root_v;
  end

  always_comb begin
    case (state)
      S_SYN:    step = outer + 4'd1;
      S_CHIEN:  step = (outer == GF_ORDER) ? 4'd0 : outer;
      S_FN_NUM: step = root_m;
      S_FN_DEN: step = add15(root_m, root_m);
      default:  step = 4'd0;
    endcase
  end

  always_comb begin
    mul_a = 4'd0;
    mul_b = 4'd0;
    case (state)
      S_SYN: begin
        mul_a = rw[idx];
        mul_b = EXP_TAB[ex];
      end
      S_ERA_UPD: begin
        mul_a = EXP_TAB[idx];
        mul_b = loc[inner - 3'd1];
      end
      S_BM_DISC: begin
        mul_a = loc[inner];
        mul_b = syn[r - 3'd1 - inner];
      end
      S_BM_T: begin
        mul_a = d;
        mul_b = corr[inner];
      end
      S_BM_C: begin
        mul_a = loc[inner];
        mul_b = gf_inv(d);
      end
      S_CHIEN: begin
        mul_a = loc[inner];
        mul_b = EXP_TAB[ex];
      end
      S_EVAL: begin
        mul_a = syn[outer[2:0] - inner];
        mul_b = loc[inner];
      end
      S_FN_NUM: begin
        mul_a = ev[inner];
        mul_b = EXP_TAB[ex];
      end
      S_FN_DEN: begin
        mul_a = loc[inner + 3'd1];
        mul_b = EXP_TAB[ex];
      end
      S_FN_VAL: begin
        mul_a = num;
        mul_b = gf_inv(d);
      end
      default: begin
        mul_a = 4'd0;
        mul_b = 4'd0;
      end
    endcase
  end

  assign prod = gf_mul(mul_a, mul_b);
  assign sum  = acc ^ prod;

  always_comb begin
    top_eval = (deg < outer[2:0]) ? deg : outer[2:0];
    top_den  = ((deg < 3'd4) ? deg : 3'd4) & 3'b110;
    lhs      = {el, 1'b0};
    rhs      = {2'b00, r} + {1'b0, erasures} - 5'd1;
    bm_take  = (lhs <= rhs);
    chk_fail = (cnt != {1'b0, deg}) || (cnt > MAX_FIX);
  end

  always_comb begin
    deg_calc = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (loc[i] != 4'd0) begin
        deg_calc = 3'(i);
      end
    end
  end

  always_comb begin
    fix = 4'd0;
    for (int j = 0; j < 5; j++) begin
      if (4'(j) < cnt && (GF_ORDER - roots[j]) == idx) begin
        fix = fix ^ vals[j];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_acc && idx == LAST_POS) state_next = S_SYN;
      end
      S_SYN: begin
        if (idx == LAST_POS && outer == 4'd4) state_next = S_SYN_CHK;
      end
      S_SYN_CHK: begin
        if (!nz || erasures > MAX_FIX) state_next = S_OUT;
        else state_next = S_ERA_SCAN;
      end
      S_ERA_SCAN: begin
        if (em[idx] && deg < 3'd5) state_next = S_ERA_UPD;
        else if (idx == LAST_POS) state_next = S_ERA_DONE;
      end
      S_ERA_UPD: begin
        if (inner == 3'd1) state_next = (idx == LAST_POS) ? S_ERA_DONE : S_ERA_SCAN;
      end
      S_ERA_DONE: begin
        state_next = (erasures == MAX_FIX) ? S_DEG : S_BM_DISC;
      end
      S_BM_DISC: begin
        if (inner == r - 3'd1) state_next = S_BM_DEC;
      end
      S_BM_DEC: begin
        state_next = (d != 4'd0) ? S_BM_T : S_BM_END;
      end
      S_BM_T: begin
        if (inner == 3'd4) state_next = bm_take ? S_BM_C : S_BM_END;
      end
      S_BM_C: begin
        if (inner == 3'd5) state_next = S_BM_END;
      end
      S_BM_END: begin
        state_next = (r == 3'd5) ? S_DEG : S_BM_DISC;
      end
      S_DEG: begin
        state_next = S_CHIEN;
      end
      S_CHIEN: begin
        if (inner == deg && outer == GF_ORDER) state_next = S_CHK;
      end
      S_CHK: begin
        state_next = chk_fail ? S_OUT : S_EVAL;
      end
      S_EVAL: begin
        if (inner == top_eval && outer == 4'd4) begin
          state_next = (cnt == 4'd0) ? S_OUT : S_FN_NUM;
        end
      end
      S_FN_NUM: begin
        if (inner == 3'd4) state_next = S_FN_DEN;
      end
      S_FN_DEN: begin
        if (inner == top_den) state_next = (sum == 4'd0) ? S_OUT : S_FN_VAL;
      end
      S_FN_VAL: begin
        state_next = (outer + 4'd1 == cnt) ? S_OUT : S_FN_NUM;
      end
      S_OUT: begin
        if (out_acc && idx == LAST_POS) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    s_tready = (state == S_LOAD);
    m_tvalid = (state == S_OUT);
    m_tlast  = (idx == LAST_POS);
    m_tdata  = {3'b000,
                (status == ST_FIXED) ? cnt[2:0] : 3'd0,
                status,
                idx,
                rw[idx] ^ ((status == ST_FIXED) ? fix : 4'd0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 4'd0;
      erasures <= 4'd0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            rw[idx] <= s_tdata[3:0];
            em[idx] <= s_tuser;
            if (s_tuser) erasures <= erasures + 4'd1;
            if (idx == LAST_POS) begin
              idx   <= 4'd0;
              outer <= 4'd0;
              acc   <= 4'd0;
              ex    <= 4'd0;
              nz    <= 1'b0;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        S_SYN: begin
          if (idx == LAST_POS) begin
            syn[outer[2:0]] <= sum;
            nz    <= nz | (sum != 4'd0);
            acc   <= 4'd0;
            ex    <= 4'd0;
            idx   <= 4'd0;
            outer <= outer + 4'd1;
          end else begin
            acc <= sum;
            ex  <= add15(ex, step);
            idx <= idx + 4'd1;
          end
        end
        S_SYN_CHK: begin
          loc[0] <= 4'd1;
          for (int i = 1; i < 6; i++) loc[i] <= 4'd0;
          deg <= 3'd0;
          idx <= 4'd0;
          if (!nz) status <= ST_OK;
          else status <= ST_FAIL;
        end
        S_ERA_SCAN: begin
          if (em[idx] && deg < 3'd5) begin
            deg   <= deg + 3'd1;
            inner <= deg + 3'd1;
          end else if (idx != LAST_POS) begin
            idx <= idx + 4'd1;
          end
        end
        S_ERA_UPD: begin
          loc[inner] <= loc[inner] ^ prod;
          if (inner == 3'd1) begin
            if (idx != LAST_POS) idx <= idx + 4'd1;
          end else begin
            inner <= inner - 3'd1;
          end
        end
        S_ERA_DONE: begin
          for (int i = 0; i < 6; i++) corr[i] <= loc[i];
          r     <= erasures[2:0] + 3'd1;
          el    <= erasures;
          inner <= 3'd0;
          acc   <= 4'd0;
        end
        S_BM_DISC: begin
          if (inner == r - 3'd1) begin
            d   <= sum;
            acc <= 4'd0;
          end else begin
            acc   <= sum;
            inner <= inner + 3'd1;
          end
        end
        S_BM_DEC: begin
          inner <= 3'd0;
          take  <= 1'b0;
        end
        S_BM_T: begin
          tp[inner + 3'd1] <= loc[inner + 3'd1] ^ prod;
          if (inner == 3'd0) tp[0] <= loc[0];
          if (inner == 3'd4) begin
            inner <= 3'd0;
            if (bm_take) begin
              take <= 1'b1;
              el   <= {1'b0, r} + erasures - el;
            end
          end else begin
            inner <= inner + 3'd1;
          end
        end
        S_BM_C: begin
          corr[inner] <= prod;
          if (inner != 3'd5) inner <= inner + 3'd1;
        end
        S_BM_END: begin
          if (!take) begin
            corr[0] <= 4'd0;
            for (int i = 1; i < 6; i++) corr[i] <= corr[i - 1];
          end
          if (d != 4'd0) begin
            for (int i = 0; i < 6; i++) loc[i] <= tp[i];
          end
          r     <= r + 3'd1;
          inner <= 3'd0;
          acc   <= 4'd0;
        end
        S_DEG: begin
          deg   <= deg_calc;
          outer <= 4'd1;
          inner <= 3'd0;
          acc   <= 4'd0;
          ex    <= 4'd0;
          cnt   <= 4'd0;
        end
        S_CHIEN: begin
          if (inner == deg) begin
            if (sum == 4'd0) begin
              if (cnt < MAX_FIX) roots[cnt[2:0]] <= outer;
              cnt <= cnt + 4'd1;
            end
            acc   <= 4'd0;
            ex    <= 4'd0;
            inner <= 3'd0;
            outer <= outer + 4'd1;
          end else begin
            acc   <= sum;
            ex    <= add15(ex, step);
            inner <= inner + 3'd1;
          end
        end
        S_CHK: begin
          outer <= 4'd0;
          inner <= 3'd0;
          acc   <= 4'd0;
          idx   <= 4'd0;
          if (chk_fail) status <= ST_FAIL;
        end
        S_EVAL: begin
          if (inner == top_eval) begin
            ev[outer[2:0]] <= sum;
            acc   <= 4'd0;
            inner <= 3'd0;
            ex    <= 4'd0;
            if (outer == 4'd4) begin
              outer <= 4'd0;
              if (cnt == 4'd0) status <= ST_FIXED;
            end else begin
              outer <= outer + 4'd1;
            end
          end else begin
            acc   <= sum;
            inner <= inner + 3'd1;
          end
        end
        S_FN_NUM: begin
          if (inner == 3'd4) begin
            num   <= sum;
            acc   <= 4'd0;
            inner <= 3'd0;
            ex    <= 4'd0;
          end else begin
            acc   <= sum;
            ex    <= add15(ex, step);
            inner <= inner + 3'd1;
          end
        end
        S_FN_DEN: begin
          if (inner == top_den) begin
            d   <= sum;
            acc <= 4'd0;
            if (sum == 4'd0) status <= ST_FAIL;
          end else begin
            acc   <= sum;
            ex    <= add15(ex, step);
            inner <= inner + 3'd2;
          end
        end
        S_FN_VAL: begin
          vals[outer[2:0]] <= prod;
          outer <= outer + 4'd1;
          inner <= 3'd0;
          ex    <= 4'd0;
          if (outer + 4'd1 == cnt) status <= ST_FIXED;
        end
        S_OUT: begin
          if (out_acc) begin
            if (idx == LAST_POS) begin
              idx      <= 4'd0;
              erasures <= 4'd0;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        default: begin
          idx <= 4'd0;
        end
      endcase
    end
  end

  `RS15_ASSERT_SAME(a_sides_exclusive, s_tready, !m_tvalid, "load and emit overlap")
  `RS15_ASSERT_NEXT(a_back_to_load, out_acc && m_tlast, s_tready, "no reload after word")
  `RS15_ASSERT_SAME(a_fail_no_count, m_tvalid && status == ST_FAIL, m_tdata[12:10] == 3'd0,
                    "count on failed word")

endmodule

`default_nettype wire
